// File: src/last_note_priority_stack_top_defines.svh
// ---------------------------------------------------------------------------
// last note priority stack - assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef LAST_NOTE_PRIORITY_STACK_TOP_DEFINES_SVH
`define LAST_NOTE_PRIORITY_STACK_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LNPS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define LNPS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/lnps_pkg.sv
// ---------------------------------------------------------------------------
// lnps_pkg
// types and constants shared by the last note priority stack
// ---------------------------------------------------------------------------
package lnps_pkg;

  localparam int LNPS_STACK_DEPTH = 16;

  localparam int LNPS_CMD_W  = 3;
  localparam int LNPS_KEY_W  = 7;
  localparam int LNPS_VAL_W  = 14;
  localparam int LNPS_TS_W   = 32;

  localparam logic [LNPS_CMD_W-1:0] CMD_NOTE_ON  = 3'd0;
  localparam logic [LNPS_CMD_W-1:0] CMD_NOTE_OFF = 3'd1;
  localparam logic [LNPS_CMD_W-1:0] CMD_CTRL     = 3'd2;
  localparam logic [LNPS_CMD_W-1:0] CMD_BEND     = 3'd3;
  localparam logic [LNPS_CMD_W-1:0] CMD_UNKNOWN  = 3'd4;

  // one held note
  typedef struct packed {
    logic [LNPS_KEY_W-1:0] note;
    logic [LNPS_VAL_W-1:0] vel;
    logic [LNPS_TS_W-1:0]  ts;
  } entry_t;

  // one emitted event
  typedef struct packed {
    logic [LNPS_CMD_W-1:0] kind;
    logic [LNPS_KEY_W-1:0] key;
    logic [LNPS_VAL_W-1:0] val;
    logic [LNPS_TS_W-1:0]  ts;
  } result_t;

  // memory port strobes from the sequencer
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_cmd_t;

endpackage

// File: src/lnps_store.sv
// ---------------------------------------------------------------------------
// lnps_store
// note stack storage: one write port, one read port with registered data
// ---------------------------------------------------------------------------
module lnps_store #(
  parameter int STACK_DEPTH = lnps_pkg::LNPS_STACK_DEPTH
) (
  input  logic                           clk,
  input  lnps_pkg::mem_cmd_t             mem_cmd,
  input  logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
  input  logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
  input  lnps_pkg::entry_t               wr_data,
  output lnps_pkg::entry_t               rd_data
);
  import lnps_pkg::*;

  entry_t mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (mem_cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/lnps_seq.sv
// ---------------------------------------------------------------------------
// lnps_seq
// sequencer: push, compacting scan with one shared note compare, re-trigger
// ---------------------------------------------------------------------------
module lnps_seq #(
  parameter int STACK_DEPTH = lnps_pkg::LNPS_STACK_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                event_valid,
  output logic                                event_ready,
  input  logic [lnps_pkg::LNPS_CMD_W-1:0]     command,
  input  logic [lnps_pkg::LNPS_KEY_W-1:0]     key_or_param,
  input  logic [lnps_pkg::LNPS_VAL_W-1:0]     value,
  input  logic [lnps_pkg::LNPS_TS_W-1:0]      time_stamp,
  output lnps_pkg::mem_cmd_t                  mem_cmd,
  output logic [$clog2(STACK_DEPTH)-1:0]      rd_addr,
  output logic [$clog2(STACK_DEPTH)-1:0]      wr_addr,
  output lnps_pkg::entry_t                    wr_data,
  input  lnps_pkg::entry_t                    rd_data,
  output logic                                res_valid,
  input  logic                                res_take,
  output lnps_pkg::result_t                   res
);
  import lnps_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_DONE  = 7'b0001000,
    S_PUSH  = 7'b0010000,
    S_TOP   = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t                state;
  logic [CW-1:0]         count;
  logic [AW-1:0]         rd_idx;
  logic [CW-1:0]         w;
  logic [LNPS_CMD_W-1:0] cur_cmd;
  logic [LNPS_KEY_W-1:0] cur_key;
  logic [LNPS_VAL_W-1:0] cur_val;
  logic [LNPS_TS_W-1:0]  cur_ts;

  logic          keep;
  logic          last;
  logic [CW-1:0] w_dec;

  assign event_ready = (state == S_IDLE);
  assign res_valid   = (state == S_EMIT);

  // note-on on a full stack drops entry 0, note-off drops matching notes
  assign keep  = (cur_cmd == CMD_NOTE_ON) ? (rd_idx != '0) : (rd_data.note != cur_key);
  assign last  = ((CW'(rd_idx) + CW'(1)) == count);
  assign w_dec = w - CW'(1);

  always_comb begin
    mem_cmd.rd_en = (state == S_READ) ||
                    ((state == S_DONE) && (cur_cmd == CMD_NOTE_OFF) && (w != '0));
    mem_cmd.wr_en = ((state == S_CHECK) && keep) || (state == S_PUSH);
    rd_addr       = (state == S_DONE) ? w_dec[AW-1:0] : rd_idx;
    wr_addr       = w[AW-1:0];
    if (state == S_PUSH) begin
      wr_data = '{note: cur_key, vel: cur_val, ts: cur_ts};
    end else begin
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (event_valid) begin
            cur_cmd <= command;
            cur_key <= key_or_param;
            cur_val <= value;
            cur_ts  <= time_stamp;
            case (command)
              CMD_NOTE_ON: begin
                if (count == CW'(STACK_DEPTH)) begin
                  rd_idx <= '0;
                  w      <= '0;
                  state  <= S_READ;
                end else begin
                  w     <= count;
                  state <= S_PUSH;
                end
              end
              CMD_NOTE_OFF: begin
                if (count == '0) begin
                  res   <= '{kind: CMD_NOTE_OFF, key: key_or_param, val: value,
                             ts: time_stamp};
                  state <= S_EMIT;
                end else begin
                  rd_idx <= '0;
                  w      <= '0;
                  state  <= S_READ;
                end
              end
              CMD_CTRL: begin
                res   <= '{kind: CMD_CTRL, key: key_or_param, val: value, ts: time_stamp};
                state <= S_EMIT;
              end
              CMD_BEND: begin
                res   <= '{kind: CMD_BEND, key: '0, val: value, ts: time_stamp};
                state <= S_EMIT;
              end
              default: begin
                res   <= '{kind: CMD_UNKNOWN, key: '0, val: '0, ts: time_stamp};
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (keep) begin
            w <= w + CW'(1);
          end
          if (last) begin
            state <= S_DONE;
          end else begin
            rd_idx <= rd_idx + AW'(1);
            state  <= S_READ;
          end
        end
        S_DONE: begin
          count <= w;
          if (cur_cmd == CMD_NOTE_ON) begin
            state <= S_PUSH;
          end else if (w == '0) begin
            res   <= '{kind: CMD_NOTE_OFF, key: cur_key, val: cur_val, ts: cur_ts};
            state <= S_EMIT;
          end else begin
            state <= S_TOP;
          end
        end
        S_PUSH: begin
          count <= w + CW'(1);
          res   <= '{kind: CMD_NOTE_ON, key: cur_key, val: cur_val, ts: cur_ts};
          state <= S_EMIT;
        end
        S_TOP: begin
          // re-trigger the most recent remaining note
          res   <= '{kind: CMD_NOTE_ON, key: rd_data.note, val: rd_data.vel,
                     ts: rd_data.ts};
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/last_note_priority_stack_top.sv
// ---------------------------------------------------------------------------
// last_note_priority_stack_top
// monophonic last note priority: held note stack with re-trigger on release
// ---------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  event    | event_valid / event_ready  | command, key_or_param, value, time_stamp
//  result   | result_valid / result_ready| event_res, out_key_or_param, out_value,
//           |                            | out_time_stamp
//
//  one transaction at a time; event_ready is low while a transaction is in work
//  controller, bend, unknown and a note-off on an empty stack go straight to the
//  result; a note-on with room pushes; a full-stack note-on or a note-off scans
//  every held entry, and a note-off then reads the new top unless none remain
//  reset clears the held count and result_valid; stack entries need no clearing
//  a stalled result holds the output register; the next one waits in the sequencer
// ---------------------------------------------------------------------------
module last_note_priority_stack_top #(
  parameter int STACK_DEPTH = lnps_pkg::LNPS_STACK_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            event_valid,
  output logic                            event_ready,
  input  logic [lnps_pkg::LNPS_CMD_W-1:0] command,
  input  logic [lnps_pkg::LNPS_KEY_W-1:0] key_or_param,
  input  logic [lnps_pkg::LNPS_VAL_W-1:0] value,
  input  logic [lnps_pkg::LNPS_TS_W-1:0]  time_stamp,
  output logic                            result_valid,
  input  logic                            result_ready,
  output logic [lnps_pkg::LNPS_CMD_W-1:0] event_res,
  output logic [lnps_pkg::LNPS_KEY_W-1:0] out_key_or_param,
  output logic [lnps_pkg::LNPS_VAL_W-1:0] out_value,
  output logic [lnps_pkg::LNPS_TS_W-1:0]  out_time_stamp
);
  import lnps_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);

  mem_cmd_t      mem_cmd;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        rd_data;
  logic          res_valid;
  logic          res_take;
  result_t       res;

  lnps_seq #(.STACK_DEPTH(STACK_DEPTH)) u_seq (
    .clk          (clk),
    .rst          (rst),
    .event_valid  (event_valid),
    .event_ready  (event_ready),
    .command      (command),
    .key_or_param (key_or_param),
    .value        (value),
    .time_stamp   (time_stamp),
    .mem_cmd      (mem_cmd),
    .rd_addr      (rd_addr),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_data      (rd_data),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res          (res)
  );

  lnps_store #(.STACK_DEPTH(STACK_DEPTH)) u_store (
    .clk     (clk),
    .mem_cmd (mem_cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  // output register, loads when empty or being drained
  assign res_take = res_valid && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      event_res        <= res.kind;
      out_key_or_param <= res.key;
      out_value        <= res.val;
      out_time_stamp   <= res.ts;
    end
  end

endmodule

// File: src/lnps_checker.sv
// ---------------------------------------------------------------------------
// lnps_checker
// port-level checks for the last note priority stack
// ---------------------------------------------------------------------------
`include "last_note_priority_stack_top_defines.svh"

module lnps_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            event_valid,
  input logic                            event_ready,
  input logic                            result_valid,
  input logic                            result_ready,
  input logic [lnps_pkg::LNPS_CMD_W-1:0] event_res,
  input logic [lnps_pkg::LNPS_KEY_W-1:0] out_key_or_param,
  input logic [lnps_pkg::LNPS_VAL_W-1:0] out_value,
  input logic [lnps_pkg::LNPS_TS_W-1:0]  out_time_stamp
);
  import lnps_pkg::*;

  `LNPS_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid, "result dropped while stalled")
  `LNPS_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(event_res) && $stable(out_key_or_param) && $stable(out_value) && $stable(out_time_stamp), "result payload changed while stalled")
  `LNPS_ASSERT_NEXT(a_one_at_a_time, event_valid && event_ready, !event_ready, "new transaction taken while one is in work")
  `LNPS_ASSERT_NOW(a_kind_legal, result_valid, event_res == CMD_NOTE_ON || event_res == CMD_NOTE_OFF || event_res == CMD_CTRL || event_res == CMD_BEND || event_res == CMD_UNKNOWN, "illegal result kind")
  `LNPS_ASSERT_NOW(a_unknown_zero, result_valid && (event_res == CMD_UNKNOWN), out_key_or_param == '0 && out_value == '0, "unknown result carries key or value")

endmodule

bind last_note_priority_stack_top lnps_checker u_lnps_checker (.*);
